// ===== rtl/ase_pkg.sv =====
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types and constants for the ascending sort engine.
// ----------------------------------------------------------------------------
package ase_pkg;

  // Width of the value fields on the ports.
  localparam int FIELD_BITS = 16;

  // Per-cycle command that the top level gives to every cell of the chain.
  typedef struct packed {
    logic load;   // insert the broadcast value
    logic shift;  // move every entry one cell toward the output
  } ase_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } ase_state_t;

endpackage

// ===== rtl/ascending_sort_engine_top.sv =====
// ----------------------------------------------------------------------------
// ascending_sort_engine_top
// Streaming insertion sorter built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  sample_value, batch_end
//   output   out_valid/out_stall  sorted_value, run_end, dropped_any
//
// While loading, one item is taken every cycle; all cells compare against
// the incoming value at once and the chain opens a slot in that same cycle.
// After the item marked batch_end, the chain shifts toward cell 0 and emits
// one item per cycle unless the output stalls; input is stalled then.
// An output stall freezes the chain. Reset empties the chain.
//
module ascending_sort_engine_top import ase_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_BITS-1:0] sample_value,
  input  logic                  batch_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] sorted_value,
  output logic                  run_end,
  output logic                  dropped_any
);

  ase_state_t            state;
  ase_state_t            state_next;
  logic                  overflow_seen;
  logic                  in_accept;
  logic                  out_accept;
  logic                  full;
  logic [VALUE_BITS-1:0] new_value;
  ase_cell_ctrl_t        ctrl;

  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic                  cell_valid [CAPACITY];
  logic                  cell_gt    [CAPACITY];

  assign in_stall   = (state != ST_LOAD);
  assign out_valid  = (state == ST_DRAIN);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign full       = cell_valid[CAPACITY-1];

  assign ctrl.load  = in_accept && !full;
  assign ctrl.shift = out_accept;

  // Width conversion between the port fields and the stored values.
  generate
    if (VALUE_BITS > FIELD_BITS) begin : g_wide
      assign new_value    = {{(VALUE_BITS-FIELD_BITS){1'b0}}, sample_value};
      assign sorted_value = cell_value[0][FIELD_BITS-1:0];
    end else if (VALUE_BITS == FIELD_BITS) begin : g_same
      assign new_value    = sample_value;
      assign sorted_value = cell_value[0];
    end else begin : g_narrow
      assign new_value    = sample_value[VALUE_BITS-1:0];
      assign sorted_value = {{(FIELD_BITS-VALUE_BITS){cell_value[0][VALUE_BITS-1]}},
                             cell_value[0]};
    end
  endgenerate

  // The last entry is the one with no valid neighbor behind it.
  assign run_end     = !cell_valid[1];
  assign dropped_any = overflow_seen;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic                  left_valid;
      logic                  left_gt;
      logic [VALUE_BITS-1:0] right_value;
      logic                  right_valid;

      if (i == 0) begin : g_head
        assign left_value = new_value;
        assign left_valid = 1'b1;
        assign left_gt    = 1'b0;
      end else begin : g_body
        assign left_value = cell_value[i-1];
        assign left_valid = cell_valid[i-1];
        assign left_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
        assign right_value = '0;
        assign right_valid = 1'b0;
      end else begin : g_inner
        assign right_value = cell_value[i+1];
        assign right_valid = cell_valid[i+1];
      end

      ase_cell #(
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .new_value   (new_value),
        .left_value  (left_value),
        .left_valid  (left_valid),
        .left_gt     (left_gt),
        .right_value (right_value),
        .right_valid (right_valid),
        .value       (cell_value[i]),
        .valid       (cell_valid[i]),
        .gt          (cell_gt[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_accept && batch_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_accept && run_end) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept && full) begin
        overflow_seen <= 1'b1;
      end else if (out_accept && run_end) begin
        overflow_seen <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ase_cell.sv =====
// ----------------------------------------------------------------------------
// ase_cell
// One cell of the insertion chain: holds a single ordered entry.
// ----------------------------------------------------------------------------
module ase_cell import ase_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ase_cell_ctrl_t        ctrl,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  left_valid,
  input  logic                  left_gt,
  input  logic [VALUE_BITS-1:0] right_value,
  input  logic                  right_valid,
  output logic [VALUE_BITS-1:0] value,
  output logic                  valid,
  output logic                  gt
);

  logic                  take;
  logic [VALUE_BITS-1:0] insert_value;

  // Strictly greater, so a new value lands after stored values equal to it.
  assign gt = valid && ($signed(value) > $signed(new_value));

  // An entry that is displaced takes its left neighbor's entry, unless the
  // left neighbor stays put, in which case the new value goes here.
  assign insert_value = left_gt ? left_value : new_value;
  assign take = gt || (!valid && left_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.load && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.load && take) begin
      value <= insert_value;
    end
  end

endmodule
